// File: sv/sfid_pkg.sv
`default_nettype none

package sfid_pkg;

    // Register indexes on the configuration channel.
    typedef enum logic [1:0] {
        CFG_CURRENT_GAIN      = 2'd0,
        CFG_VOLTAGE_GAIN      = 2'd1,
        CFG_INTEGRAL_GAIN     = 2'd2,
        CFG_VOLTAGE_REFERENCE = 2'd3
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 32;
    localparam int INTEG_W    = 48;
    localparam int DUTY_W     = 16;

    // Reset values of the configuration registers.
    localparam logic signed [GAIN_W-1:0]   CURRENT_GAIN_RST  = 32'sd890082;
    localparam logic signed [GAIN_W-1:0]   VOLTAGE_GAIN_RST  = -32'sd743386;
    localparam logic signed [GAIN_W-1:0]   INTEGRAL_GAIN_RST = -32'sd1654689099;
    localparam logic signed [SAMPLE_W-1:0] VOLTAGE_REF_RST   = 16'sd1536;

    // Sample period 1e-5 s in Q.48, positive, held as a 33-bit signed operand.
    localparam logic signed [32:0] DT_Q48 = 33'sd2814749767;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        MUL_ERR_DT,
        MUL_CURRENT,
        MUL_VOLTAGE,
        MUL_INTEGRAL
    } mul_sel_t;

    // Accumulator operation for the command sum.
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_ROUND
    } acc_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DT,
        ST_INTEG,
        ST_ADD_CUR,
        ST_ADD_VOLT,
        ST_ADD_INT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     integ_en;
        acc_op_t  acc_op;
        logic     result_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic result_busy;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/sfid_sample_if.sv
`default_nettype none

interface sfid_sample_if;
    logic                 valid;
    logic                 ready;
    logic signed [15:0]   measured_current;
    logic signed [15:0]   measured_voltage;

    modport source (output valid, output measured_current, output measured_voltage,
                    input ready);
    modport sink   (input valid, input measured_current, input measured_voltage,
                    output ready);
endinterface

`default_nettype wire

// File: sv/sfid_result_if.sv
`default_nettype none

interface sfid_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_cycle;
    logic        clamped_high;
    logic        clamped_low;

    modport source (output valid, output duty_cycle, output clamped_high,
                    output clamped_low, input ready);
    modport sink   (input valid, input duty_cycle, input clamped_high,
                    input clamped_low, output ready);
endinterface

`default_nettype wire

// File: sv/sfid_cfg_if.sv
`default_nettype none

interface sfid_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/sfid_ctrl.sv
`default_nettype none

module sfid_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire sfid_pkg::dp_status_t   status,
    output sfid_pkg::ctrl_cmd_t         cmd
);

    sfid_pkg::state_t state_reg;
    sfid_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfid_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfid_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sfid_pkg::ST_MUL_DT;
                end
            end
            sfid_pkg::ST_MUL_DT:   state_next = sfid_pkg::ST_INTEG;
            sfid_pkg::ST_INTEG:    state_next = sfid_pkg::ST_ADD_CUR;
            sfid_pkg::ST_ADD_CUR:  state_next = sfid_pkg::ST_ADD_VOLT;
            sfid_pkg::ST_ADD_VOLT: state_next = sfid_pkg::ST_ADD_INT;
            sfid_pkg::ST_ADD_INT:  state_next = sfid_pkg::ST_RESULT;
            sfid_pkg::ST_RESULT:
            begin
                if (!status.result_busy)
                begin
                    state_next = sfid_pkg::ST_IDLE;
                end
            end
            default:               state_next = sfid_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = sfid_pkg::MUL_ERR_DT;
        cmd.integ_en  = 1'b0;
        cmd.acc_op    = sfid_pkg::ACC_HOLD;
        cmd.result_en = 1'b0;
        unique case (state_reg)
            sfid_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sfid_pkg::ST_MUL_DT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sfid_pkg::MUL_ERR_DT;
            end
            sfid_pkg::ST_INTEG:
            begin
                cmd.integ_en = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = sfid_pkg::MUL_CURRENT;
            end
            sfid_pkg::ST_ADD_CUR:
            begin
                cmd.acc_op  = sfid_pkg::ACC_LOAD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sfid_pkg::MUL_VOLTAGE;
            end
            sfid_pkg::ST_ADD_VOLT:
            begin
                cmd.acc_op  = sfid_pkg::ACC_ADD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sfid_pkg::MUL_INTEGRAL;
            end
            sfid_pkg::ST_ADD_INT:
            begin
                cmd.acc_op = sfid_pkg::ACC_ADD_ROUND;
            end
            sfid_pkg::ST_RESULT:
            begin
                cmd.result_en = !status.result_busy;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sfid_datapath.sv
`default_nettype none

module sfid_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sfid_pkg::ctrl_cmd_t   cmd,
    output sfid_pkg::dp_status_t       status,
    input  wire logic signed [15:0]    measured_current,
    input  wire logic signed [15:0]    measured_voltage,
    sfid_cfg_if.sink                   cfg,
    sfid_result_if.source              result
);

    localparam logic signed [49:0] INTEG_MAX  = 50'sd140737488355327;
    localparam logic signed [49:0] INTEG_MIN  = -50'sd140737488355328;
    localparam logic signed [65:0] HALF_Q16   = 66'sd32768;
    localparam logic signed [49:0] ONE_Q32    = 50'sd4294967296;
    localparam logic        [48:0] HALF_Q32   = 49'd2147483648;

    // Configuration registers.
    logic signed [31:0] current_gain_reg;
    logic signed [31:0] voltage_gain_reg;
    logic signed [31:0] integral_gain_reg;
    logic signed [15:0] voltage_ref_reg;

    logic signed [15:0] cur_reg;
    logic signed [15:0] volt_reg;
    logic signed [16:0] err_reg;
    logic signed [47:0] integ_reg;
    logic signed [47:0] integ_next;
    logic signed [65:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic signed [49:0] acc_next;

    logic        out_valid_reg;
    logic [15:0] duty_reg;
    logic        high_reg;
    logic        low_reg;
    logic [15:0] duty_next;
    logic        high_next;
    logic        low_next;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_rnd;
    logic signed [49:0] rnd_q16;
    logic signed [49:0] integ_sum;
    logic signed [49:0] u_val;
    logic        [48:0] duty_scaled;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gain_reg  <= sfid_pkg::CURRENT_GAIN_RST;
            voltage_gain_reg  <= sfid_pkg::VOLTAGE_GAIN_RST;
            integral_gain_reg <= sfid_pkg::INTEGRAL_GAIN_RST;
            voltage_ref_reg   <= sfid_pkg::VOLTAGE_REF_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                sfid_pkg::CFG_CURRENT_GAIN:      current_gain_reg  <= cfg.data;
                sfid_pkg::CFG_VOLTAGE_GAIN:      voltage_gain_reg  <= cfg.data;
                sfid_pkg::CFG_INTEGRAL_GAIN:     integral_gain_reg <= cfg.data;
                sfid_pkg::CFG_VOLTAGE_REFERENCE: voltage_ref_reg   <= cfg.data[15:0];
            endcase
        end
    end

    // Sample capture; the voltage error is formed once here.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg  <= measured_current;
            volt_reg <= measured_voltage;
            err_reg  <= 17'(voltage_ref_reg) - 17'(measured_voltage);
        end
    end

    // Shared multiplier with a registered product.
    always_comb
    begin
        unique case (cmd.mul_sel)
            sfid_pkg::MUL_ERR_DT:
            begin
                mul_a = {{16{err_reg[16]}}, err_reg};
                mul_b = sfid_pkg::DT_Q48;
            end
            sfid_pkg::MUL_CURRENT:
            begin
                mul_a = {current_gain_reg[31], current_gain_reg};
                mul_b = {{17{cur_reg[15]}}, cur_reg};
            end
            sfid_pkg::MUL_VOLTAGE:
            begin
                mul_a = {voltage_gain_reg[31], voltage_gain_reg};
                mul_b = {{17{volt_reg[15]}}, volt_reg};
            end
            sfid_pkg::MUL_INTEGRAL:
            begin
                mul_a = {integral_gain_reg[31], integral_gain_reg};
                mul_b = {integ_reg[47], integ_reg[47:16]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
    end

    // Product rounded half up to sixteen fewer fraction bits.
    assign prod_rnd = prod_reg + HALF_Q16;
    assign rnd_q16  = $signed(prod_rnd[65:16]);

    // Integrator update with saturation at the Q7.40 bounds.
    assign integ_sum = 50'(integ_reg) + rnd_q16;

    always_comb
    begin
        priority if (integ_sum > INTEG_MAX)
        begin
            integ_next = INTEG_MAX[47:0];
        end
        else if (integ_sum < INTEG_MIN)
        begin
            integ_next = INTEG_MIN[47:0];
        end
        else
        begin
            integ_next = integ_sum[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (cmd.integ_en)
        begin
            integ_reg <= integ_next;
        end
    end

    // Sum of the three feedback terms at Q.32.
    always_comb
    begin
        unique case (cmd.acc_op)
            sfid_pkg::ACC_HOLD:      acc_next = acc_reg;
            sfid_pkg::ACC_LOAD:      acc_next = $signed(prod_reg[49:0]);
            sfid_pkg::ACC_ADD:       acc_next = acc_reg + $signed(prod_reg[49:0]);
            sfid_pkg::ACC_ADD_ROUND: acc_next = acc_reg + rnd_q16;
            default:                 acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Clamp and scale the command to a Q0.16 duty.
    assign u_val       = -acc_reg;
    assign duty_scaled = {u_val[32:0], 16'd0} - {16'd0, u_val[32:0]} + HALF_Q32;

    always_comb
    begin
        priority if (u_val > ONE_Q32)
        begin
            duty_next = 16'hFFFF;
            high_next = 1'b1;
            low_next  = 1'b0;
        end
        else if (u_val < 50'sd0)
        begin
            duty_next = 16'd0;
            high_next = 1'b0;
            low_next  = 1'b1;
        end
        else
        begin
            duty_next = duty_scaled[47:32];
            high_next = 1'b0;
            low_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_en)
        begin
            duty_reg <= duty_next;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.result_busy  = out_valid_reg && !result.ready;
    assign result.valid        = out_valid_reg;
    assign result.duty_cycle   = duty_reg;
    assign result.clamped_high = high_reg;
    assign result.clamped_low  = low_reg;

endmodule

`default_nettype wire

// File: sv/state_feedback_integral_duty_core.sv
`default_nettype none

// Channel   Direction  Payload                                      Handshake
// sample    in         measured_current, measured_voltage (Q7.8)    valid/ready
// result    out        duty_cycle (Q0.16), clamped_high, clamped_low valid/ready
// cfg       in         index (2 bits), data (32 bits)               valid/ready
//
// A request passes through the idle state that accepts it and six steps; the result
// register is loaded as the last step ends. The shared 33x33 multiplier serves four
// of those steps. The next request is accepted once the result register is loaded,
// even while that result waits; a stalled sink holds the block in its last step.
// Reset (rst_n, asynchronous) restores the gains and reference and clears the
// integrator; configuration writes are taken every cycle.

module state_feedback_integral_duty_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    sfid_sample_if.sink    sample,
    sfid_result_if.source  result,
    sfid_cfg_if.sink       cfg
);

    // Commands flow from the sequencer to the datapath; the datapath reports
    // back only whether its result register can take a new value.
    sfid_pkg::ctrl_cmd_t  cmd;
    sfid_pkg::dp_status_t status;
    logic                 in_ready;

    assign sample.ready = in_ready;

    // The sequencer walks through the integrator update, the three products
    // and the final clamp; it accepts a request only when idle.
    sfid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the integrator, the
    // shared multiplier with its product register, the command accumulator
    // and the result register.
    sfid_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .measured_current (sample.measured_current),
        .measured_voltage (sample.measured_voltage),
        .cfg              (cfg),
        .result           (result)
    );

endmodule

`default_nettype wire
